@@ rtl/core/tbv_pkg.sv @@
// Shared types, constants and fixed-point arithmetic for the three-body
// variational right-hand side datapath. No dependencies.
`default_nettype none

package tbv_pkg;

    // Number format: signed Q15.48 words.
    localparam int FRAC_BITS = 48;

    localparam logic [63:0]  ONE       = 64'(1) << FRAC_BITS;
    localparam logic [63:0]  S64_MAX   = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0]  S64_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [127:0] RND_HALF  = 128'(1) << (FRAC_BITS - 1);
    localparam logic [127:0] RECIP_NUM = 128'(1) << (2 * FRAC_BITS);

    // Configuration register map and reset values.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASS_RATIO    = 2'd0,
        CFG_PRIMARY_ONE_X = 2'd1,
        CFG_PRIMARY_TWO_X = 2'd2
    } t_cfg_idx;

    localparam logic [48:0] MASS_RATIO_RST    = 49'd3419920967034;
    localparam logic [63:0] PRIMARY_ONE_X_RST = -64'sd3419920967034;
    localparam logic [63:0] PRIMARY_TWO_X_RST = 64'sd278055055743622;

    // Input and output words.
    typedef struct packed {
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] phi_row_zero;
        logic signed [63:0] phi_row_one;
        logic signed [63:0] phi_row_two;
        logic signed [63:0] phi_row_three;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] dpos_x;
        logic signed [63:0] dpos_y;
        logic signed [63:0] dvel_x;
        logic signed [63:0] dvel_y;
        logic signed [63:0] dphi_row_zero;
        logic signed [63:0] dphi_row_one;
        logic signed [63:0] dphi_row_two;
        logic signed [63:0] dphi_row_three;
        logic               overflow_flag;
    } t_out_word;

    // Saturated result with its overflow flag.
    typedef struct packed {
        logic [63:0] val;
        logic        sat;
    } t_sres;

    // Four 32x32 partial products of a magnitude product, plus result sign.
    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
        logic        neg;
    } t_pp;

    // Square root iteration state.
    typedef struct packed {
        logic [67:0] rem;
        logic [63:0] root;
    } t_sq;

    // Reciprocal long-division state; hi collects quotient bits above bit 63.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] q;
        logic        hi;
    } t_dv;

    function automatic t_sres sadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        t_sres       r;
        s     = {a[63], a} + {b[63], b};
        r.sat = s[64] ^ s[63];
        r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
        return r;
    endfunction

    function automatic t_sres ssub(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        t_sres       r;
        s     = {a[63], a} - {b[63], b};
        r.sat = s[64] ^ s[63];
        r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    // First half of a multiply: magnitudes and the four partial products.
    function automatic t_pp smul_pp(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        t_pp         r;
        ma    = mag(a);
        mb    = mag(b);
        r.ll  = 64'(ma[31:0])  * 64'(mb[31:0]);
        r.lh  = 64'(ma[31:0])  * 64'(mb[63:32]);
        r.hl  = 64'(ma[63:32]) * 64'(mb[31:0]);
        r.hh  = 64'(ma[63:32]) * 64'(mb[63:32]);
        r.neg = a[63] ^ b[63];
        return r;
    endfunction

    // Exact 128-bit magnitude product from the partial products.
    function automatic logic [127:0] pp_sum(input t_pp pp);
        return {pp.hh, 64'd0} + {32'd0, pp.lh, 32'd0} + {32'd0, pp.hl, 32'd0}
             + {64'd0, pp.ll};
    endfunction

    // Second half of a multiply: round half away from zero, scale, saturate.
    function automatic t_sres smul_fin(input t_pp pp);
        logic [127:0] p;
        logic [127:0] m;
        t_sres        r;
        p     = pp_sum(pp) + RND_HALF;
        m     = p >> FRAC_BITS;
        r.sat = pp.neg ? (m > {64'd0, S64_MIN}) : (m > {64'd0, S64_MAX});
        if (r.sat) begin
            r.val = pp.neg ? S64_MIN : S64_MAX;
        end else begin
            r.val = pp.neg ? (~m[63:0] + 64'd1) : m[63:0];
        end
        return r;
    endfunction

    // One digit of the restoring square root: brings down two radicand bits.
    function automatic t_sq sqrt_step(input t_sq st, input logic [1:0] pair);
        logic [67:0] r2;
        logic [67:0] trial;
        t_sq         n;
        r2    = {st.rem[65:0], pair};
        trial = {2'b00, st.root, 2'b01};
        if (r2 >= trial) begin
            n.rem  = r2 - trial;
            n.root = {st.root[62:0], 1'b1};
        end else begin
            n.rem  = r2;
            n.root = {st.root[62:0], 1'b0};
        end
        return n;
    endfunction

    // One quotient bit of the reciprocal long division.
    function automatic t_dv div_step(input t_dv st, input logic nbit,
                                     input logic [63:0] d);
        logic [64:0] remx;
        logic [64:0] diff;
        logic        ge;
        t_dv         n;
        remx  = {st.rem, nbit};
        diff  = remx - {1'b0, d};
        ge    = remx >= {1'b0, d};
        n.rem = ge ? diff[63:0] : remx[63:0];
        n.hi  = st.hi | st.q[63];
        n.q   = {st.q[62:0], ge};
        return n;
    endfunction

    // Reciprocal result: zero distance or a quotient past 63 bits saturates.
    function automatic t_sres inv_fin(input t_dv st, input logic zero_dist);
        t_sres r;
        r.sat = zero_dist | st.hi | st.q[63];
        r.val = r.sat ? S64_MAX : st.q;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/three_body_variational_rhs.sv @@
// Top level of the three-body variational right-hand side pipeline.
// Depends on tbv_pkg for word types, constants and arithmetic functions.
//
// Usage:
//   Input channel: i_valid / o_stall carry one word (position, velocity and
//   one column of the sensitivity matrix). A word is taken at a clock edge
//   with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry one result word per input word,
//   in order, taken at an edge with o_valid high and i_stall low.
//   Configuration: i_cfg_wr_en writes i_cfg_data into the register chosen by
//   i_cfg_index (mass ratio, larger and smaller primary x); other indexes are
//   ignored. Write only while no word is in flight.
//   Pipeline: the length is set by the two 64-step square roots and the
//   two 128-step reciprocal divisions, one bit per stage, plus the multiply
//   and add stages. Throughput is one word per cycle while o_stall is low.
//   Stall: each of the 223 stages moves on when it is empty or the stage
//   after it moves, so gaps close up and new words still enter while a
//   finished result waits on i_stall, until no empty stage is left.
//   Reset: all stages empty, configuration back to its reset values.
`default_nettype none

module three_body_variational_rhs (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire tbv_pkg::t_in_word    i_word,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output tbv_pkg::t_out_word        o_word,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [tbv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    // Stage map.
    localparam int S_ENTRY = 0;
    localparam int S_SQPP  = 1;
    localparam int S_SQFIN = 2;
    localparam int S_RAD   = 3;
    localparam int S_SQ    = 4;
    localparam int SQ_N    = 64;
    localparam int S_DI    = S_SQ + SQ_N;
    localparam int S_DV    = S_DI + 1;
    localparam int DV_N    = 128;
    localparam int S_INV   = S_DV + DV_N;
    localparam int S_M1    = S_INV + 1;
    localparam int S_M2    = S_M1 + 2;
    localparam int S_M3    = S_M2 + 2;
    localparam int S_M4    = S_M3 + 2;
    localparam int S_A1    = S_M4 + 2;
    localparam int S_A2    = S_A1 + 1;
    localparam int S_A3    = S_A2 + 1;
    localparam int S_M5    = S_A3 + 1;
    localparam int S_A4    = S_M5 + 2;
    localparam int S_A5    = S_A4 + 1;
    localparam int S_A6    = S_A5 + 1;
    localparam int S_A7    = S_A6 + 1;
    localparam int S_M6    = S_A7 + 1;
    localparam int S_A8    = S_M6 + 2;
    localparam int S_A9    = S_A8 + 1;
    localparam int S_M7    = S_A9 + 1;
    localparam int S_A10   = S_M7 + 2;
    localparam int S_A11   = S_A10 + 1;
    localparam int NSTG    = S_A11 + 1;

    // Everything a word carries down the pipeline.
    typedef struct packed {
        logic [63:0]  x, y, vx, vy, p0, p1, p2, p3, mu, omm, dx1, dx2;
        logic [127:0] sq1, sq2, sqy, n1, n2;
        logic [63:0]  dx1sq, dx2sq, yy;
        tbv_pkg::t_sq sq_a, sq_b;
        tbv_pkg::t_dv dv_a, dv_b;
        logic         z1, z2;
        logic [63:0]  i1, i2, i1s, i2s, i13, i23, i15, i25;
        logic [63:0]  a1, a2, b1, b2, ma1, ma2, ya1, ya2;
        logic [63:0]  base1, base, sb, ax1, ay1, vy2, vx2, ax2, ay2, ax, ay;
        logic [63:0]  t1, t2, t3, t4, t5, s12, s34, s12x2, t5x2, s12x3, t5x3;
        logic [63:0]  uxx, uyy, u6, u6x2, uxy;
        logic [63:0]  m1, m2, m3, m4, e1, e2, e3, e4, d2, d3;
        tbv_pkg::t_pp [5:0] pp;
        logic         sat;
    } t_ctx;

    // Configuration registers.
    logic [48:0] r_mass_ratio;
    logic [63:0] r_p1x;
    logic [63:0] r_p2x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass_ratio <= tbv_pkg::MASS_RATIO_RST;
            r_p1x        <= tbv_pkg::PRIMARY_ONE_X_RST;
            r_p2x        <= tbv_pkg::PRIMARY_TWO_X_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tbv_pkg::CFG_MASS_RATIO:    r_mass_ratio <= i_cfg_data[48:0];
                tbv_pkg::CFG_PRIMARY_ONE_X: r_p1x        <= i_cfg_data;
                tbv_pkg::CFG_PRIMARY_TWO_X: r_p2x        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage registers and advance chain.
    t_ctx              r_ctx [NSTG];
    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   w_adv;
    logic [NSTG-1:0]   w_vin;

    assign w_vin            = {r_vld[NSTG-2:0], i_valid};
    assign w_adv[NSTG-1]    = !r_vld[NSTG-1] || !i_stall;
    assign o_stall          = !w_adv[0];

    for (genvar k = 0; k < NSTG - 1; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        t_ctx n_ctx;

        // Valid bit travels with the word.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_vld[k] <= w_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k]) begin
                r_ctx[k] <= n_ctx;
            end
        end

        if (k == S_ENTRY) begin : g_entry
            // Capture the word and the configuration, form the offsets.
            always_comb begin
                tbv_pkg::t_sres s0, s1, s2;
                logic [63:0]    mu64;
                mu64         = {15'd0, r_mass_ratio};
                s0           = tbv_pkg::ssub(tbv_pkg::ONE, mu64);
                s1           = tbv_pkg::ssub(i_word.pos_x, r_p1x);
                s2           = tbv_pkg::ssub(i_word.pos_x, r_p2x);
                n_ctx        = '0;
                n_ctx.x      = i_word.pos_x;
                n_ctx.y      = i_word.pos_y;
                n_ctx.vx     = i_word.vel_x;
                n_ctx.vy     = i_word.vel_y;
                n_ctx.p0     = i_word.phi_row_zero;
                n_ctx.p1     = i_word.phi_row_one;
                n_ctx.p2     = i_word.phi_row_two;
                n_ctx.p3     = i_word.phi_row_three;
                n_ctx.mu     = mu64;
                n_ctx.omm    = s0.val;
                n_ctx.dx1    = s1.val;
                n_ctx.dx2    = s2.val;
                n_ctx.sat    = s0.sat | s1.sat | s2.sat;
            end
        end else if (k == S_SQPP) begin : g_sqpp
            // Squares of the offsets and of y, partial products.
            always_comb begin
                n_ctx       = r_ctx[k-1];
                n_ctx.pp[0] = tbv_pkg::smul_pp(r_ctx[k-1].dx1, r_ctx[k-1].dx1);
                n_ctx.pp[1] = tbv_pkg::smul_pp(r_ctx[k-1].dx2, r_ctx[k-1].dx2);
                n_ctx.pp[2] = tbv_pkg::smul_pp(r_ctx[k-1].y, r_ctx[k-1].y);
            end
        end else if (k == S_SQFIN) begin : g_sqfin
            // Exact squares for the distances and scaled squares for A.
            always_comb begin
                tbv_pkg::t_sres f0, f1, f2;
                f0          = tbv_pkg::smul_fin(r_ctx[k-1].pp[0]);
                f1          = tbv_pkg::smul_fin(r_ctx[k-1].pp[1]);
                f2          = tbv_pkg::smul_fin(r_ctx[k-1].pp[2]);
                n_ctx       = r_ctx[k-1];
                n_ctx.sq1   = tbv_pkg::pp_sum(r_ctx[k-1].pp[0]);
                n_ctx.sq2   = tbv_pkg::pp_sum(r_ctx[k-1].pp[1]);
                n_ctx.sqy   = tbv_pkg::pp_sum(r_ctx[k-1].pp[2]);
                n_ctx.dx1sq = f0.val;
                n_ctx.dx2sq = f1.val;
                n_ctx.yy    = f2.val;
                n_ctx.sat   = r_ctx[k-1].sat | f0.sat | f1.sat | f2.sat;
            end
        end else if (k == S_RAD) begin : g_rad
            // Radicands and square root start.
            always_comb begin
                n_ctx      = r_ctx[k-1];
                n_ctx.n1   = r_ctx[k-1].sq1 + r_ctx[k-1].sqy;
                n_ctx.n2   = r_ctx[k-1].sq2 + r_ctx[k-1].sqy;
                n_ctx.sq_a = '0;
                n_ctx.sq_b = '0;
            end
        end else if (k >= S_SQ && k < S_SQ + SQ_N) begin : g_sqrt
            // One root bit per stage, most significant first.
            localparam int B = SQ_N - 1 - (k - S_SQ);
            always_comb begin
                n_ctx      = r_ctx[k-1];
                n_ctx.sq_a = tbv_pkg::sqrt_step(r_ctx[k-1].sq_a, r_ctx[k-1].n1[2*B +: 2]);
                n_ctx.sq_b = tbv_pkg::sqrt_step(r_ctx[k-1].sq_b, r_ctx[k-1].n2[2*B +: 2]);
            end
        end else if (k == S_DI) begin : g_div_init
            // Rounded dividend for the reciprocals.
            always_comb begin
                n_ctx      = r_ctx[k-1];
                n_ctx.n1   = tbv_pkg::RECIP_NUM + {65'd0, r_ctx[k-1].sq_a.root[63:1]};
                n_ctx.n2   = tbv_pkg::RECIP_NUM + {65'd0, r_ctx[k-1].sq_b.root[63:1]};
                n_ctx.z1   = r_ctx[k-1].sq_a.root == 64'd0;
                n_ctx.z2   = r_ctx[k-1].sq_b.root == 64'd0;
                n_ctx.dv_a = '0;
                n_ctx.dv_b = '0;
            end
        end else if (k >= S_DV && k < S_DV + DV_N) begin : g_div
            // One quotient bit per stage, most significant first.
            localparam int I = DV_N - 1 - (k - S_DV);
            always_comb begin
                n_ctx      = r_ctx[k-1];
                n_ctx.dv_a = tbv_pkg::div_step(r_ctx[k-1].dv_a, r_ctx[k-1].n1[I],
                                               r_ctx[k-1].sq_a.root);
                n_ctx.dv_b = tbv_pkg::div_step(r_ctx[k-1].dv_b, r_ctx[k-1].n2[I],
                                               r_ctx[k-1].sq_b.root);
            end
        end else if (k == S_INV) begin : g_inv
            // Reciprocal distances with saturation.
            always_comb begin
                tbv_pkg::t_sres f0, f1;
                f0        = tbv_pkg::inv_fin(r_ctx[k-1].dv_a, r_ctx[k-1].z1);
                f1        = tbv_pkg::inv_fin(r_ctx[k-1].dv_b, r_ctx[k-1].z2);
                n_ctx     = r_ctx[k-1];
                n_ctx.i1  = f0.val;
                n_ctx.i2  = f1.val;
                n_ctx.sat = r_ctx[k-1].sat | f0.sat | f1.sat;
            end
        end else if (k == S_M1 || k == S_M2 || k == S_M3 || k == S_M4 ||
                     k == S_M5 || k == S_M6 || k == S_M7) begin : g_mul_pp
            // Partial products of the multiplies of this level.
            always_comb begin
                t_ctx c;
                c     = r_ctx[k-1];
                n_ctx = c;
                case (k)
                    S_M1: begin
                        n_ctx.pp[0] = tbv_pkg::smul_pp(c.i1, c.i1);
                        n_ctx.pp[1] = tbv_pkg::smul_pp(c.i2, c.i2);
                    end
                    S_M2: begin
                        n_ctx.pp[0] = tbv_pkg::smul_pp(c.i1s, c.i1);
                        n_ctx.pp[1] = tbv_pkg::smul_pp(c.i2s, c.i2);
                    end
                    S_M3: begin
                        n_ctx.pp[0] = tbv_pkg::smul_pp(c.i13, c.i1s);
                        n_ctx.pp[1] = tbv_pkg::smul_pp(c.i23, c.i2s);
                        n_ctx.pp[2] = tbv_pkg::smul_pp(c.omm, c.i13);
                        n_ctx.pp[3] = tbv_pkg::smul_pp(c.mu, c.i23);
                    end
                    S_M4: begin
                        n_ctx.pp[0] = tbv_pkg::smul_pp(c.omm, c.i15);
                        n_ctx.pp[1] = tbv_pkg::smul_pp(c.mu, c.i25);
                        n_ctx.pp[2] = tbv_pkg::smul_pp(c.a1, c.dx1);
                        n_ctx.pp[3] = tbv_pkg::smul_pp(c.a2, c.dx2);
                        n_ctx.pp[4] = tbv_pkg::smul_pp(c.a1, c.y);
                        n_ctx.pp[5] = tbv_pkg::smul_pp(c.a2, c.y);
                    end
                    S_M5: begin
                        n_ctx.pp[0] = tbv_pkg::smul_pp(c.b1, c.dx1sq);
                        n_ctx.pp[1] = tbv_pkg::smul_pp(c.b2, c.dx2sq);
                        n_ctx.pp[2] = tbv_pkg::smul_pp(c.b1, c.dx1);
                        n_ctx.pp[3] = tbv_pkg::smul_pp(c.b2, c.dx2);
                        n_ctx.pp[4] = tbv_pkg::smul_pp(c.yy, c.sb);
                    end
                    S_M6: begin
                        n_ctx.pp[0] = tbv_pkg::smul_pp(c.y, c.s34);
                    end
                    S_M7: begin
                        n_ctx.pp[0] = tbv_pkg::smul_pp(c.uxx, c.p0);
                        n_ctx.pp[1] = tbv_pkg::smul_pp(c.uxy, c.p1);
                        n_ctx.pp[2] = tbv_pkg::smul_pp(c.uxy, c.p0);
                        n_ctx.pp[3] = tbv_pkg::smul_pp(c.uyy, c.p1);
                    end
                    default: ;
                endcase
            end
        end else if (k == S_M1 + 1 || k == S_M2 + 1 || k == S_M3 + 1 ||
                     k == S_M4 + 1 || k == S_M5 + 1 || k == S_M6 + 1 ||
                     k == S_M7 + 1) begin : g_mul_fin
            // Rounding, scaling and saturation of every slot, then routing.
            always_comb begin
                t_ctx           c;
                tbv_pkg::t_sres f [6];
                logic           fsat;
                c    = r_ctx[k-1];
                fsat = c.sat;
                for (int j = 0; j < 6; j++) begin
                    f[j] = tbv_pkg::smul_fin(c.pp[j]);
                end
                n_ctx = c;
                case (k)
                    S_M1 + 1: begin
                        n_ctx.i1s = f[0].val;
                        n_ctx.i2s = f[1].val;
                        fsat      = fsat | f[0].sat | f[1].sat;
                    end
                    S_M2 + 1: begin
                        n_ctx.i13 = f[0].val;
                        n_ctx.i23 = f[1].val;
                        fsat      = fsat | f[0].sat | f[1].sat;
                    end
                    S_M3 + 1: begin
                        n_ctx.i15 = f[0].val;
                        n_ctx.i25 = f[1].val;
                        n_ctx.a1  = f[2].val;
                        n_ctx.a2  = f[3].val;
                        fsat      = fsat | f[0].sat | f[1].sat | f[2].sat | f[3].sat;
                    end
                    S_M4 + 1: begin
                        n_ctx.b1  = f[0].val;
                        n_ctx.b2  = f[1].val;
                        n_ctx.ma1 = f[2].val;
                        n_ctx.ma2 = f[3].val;
                        n_ctx.ya1 = f[4].val;
                        n_ctx.ya2 = f[5].val;
                        fsat      = fsat | f[0].sat | f[1].sat | f[2].sat | f[3].sat
                                  | f[4].sat | f[5].sat;
                    end
                    S_M5 + 1: begin
                        n_ctx.t1  = f[0].val;
                        n_ctx.t2  = f[1].val;
                        n_ctx.t3  = f[2].val;
                        n_ctx.t4  = f[3].val;
                        n_ctx.t5  = f[4].val;
                        fsat      = fsat | f[0].sat | f[1].sat | f[2].sat | f[3].sat
                                  | f[4].sat;
                    end
                    S_M6 + 1: begin
                        n_ctx.u6  = f[0].val;
                        fsat      = fsat | f[0].sat;
                    end
                    S_M7 + 1: begin
                        n_ctx.m1  = f[0].val;
                        n_ctx.m2  = f[1].val;
                        n_ctx.m3  = f[2].val;
                        n_ctx.m4  = f[3].val;
                        fsat      = fsat | f[0].sat | f[1].sat | f[2].sat | f[3].sat;
                    end
                    default: ;
                endcase
                n_ctx.sat = fsat;
            end
        end else begin : g_add
            // Saturating add and subtract levels.
            always_comb begin
                t_ctx           c;
                tbv_pkg::t_sres s0, s1, s2, s3;
                c  = r_ctx[k-1];
                s0 = '0;
                s1 = '0;
                s2 = '0;
                s3 = '0;
                n_ctx = c;
                case (k)
                    S_A1: begin
                        s0          = tbv_pkg::ssub(tbv_pkg::ONE, c.a1);
                        s1          = tbv_pkg::sadd(c.b1, c.b2);
                        s2          = tbv_pkg::ssub(c.x, c.ma1);
                        s3          = tbv_pkg::ssub(c.y, c.ya1);
                        n_ctx.base1 = s0.val;
                        n_ctx.sb    = s1.val;
                        n_ctx.ax1   = s2.val;
                        n_ctx.ay1   = s3.val;
                    end
                    S_A2: begin
                        s0          = tbv_pkg::ssub(c.base1, c.a2);
                        s1          = tbv_pkg::ssub(c.ax1, c.ma2);
                        s2          = tbv_pkg::ssub(c.ay1, c.ya2);
                        s3          = tbv_pkg::sadd(c.vy, c.vy);
                        n_ctx.base  = s0.val;
                        n_ctx.ax2   = s1.val;
                        n_ctx.ay2   = s2.val;
                        n_ctx.vy2   = s3.val;
                    end
                    S_A3: begin
                        s0          = tbv_pkg::sadd(c.vx, c.vx);
                        s1          = tbv_pkg::sadd(c.ax2, c.vy2);
                        n_ctx.vx2   = s0.val;
                        n_ctx.ax    = s1.val;
                    end
                    S_A4: begin
                        s0          = tbv_pkg::sadd(c.t1, c.t2);
                        s1          = tbv_pkg::sadd(c.t3, c.t4);
                        s2          = tbv_pkg::ssub(c.ay2, c.vx2);
                        n_ctx.s12   = s0.val;
                        n_ctx.s34   = s1.val;
                        n_ctx.ay    = s2.val;
                    end
                    S_A5: begin
                        s0          = tbv_pkg::sadd(c.s12, c.s12);
                        s1          = tbv_pkg::sadd(c.t5, c.t5);
                        n_ctx.s12x2 = s0.val;
                        n_ctx.t5x2  = s1.val;
                    end
                    S_A6: begin
                        s0          = tbv_pkg::sadd(c.s12x2, c.s12);
                        s1          = tbv_pkg::sadd(c.t5x2, c.t5);
                        n_ctx.s12x3 = s0.val;
                        n_ctx.t5x3  = s1.val;
                    end
                    S_A7: begin
                        s0          = tbv_pkg::sadd(c.base, c.s12x3);
                        s1          = tbv_pkg::sadd(c.base, c.t5x3);
                        n_ctx.uxx   = s0.val;
                        n_ctx.uyy   = s1.val;
                    end
                    S_A8: begin
                        s0          = tbv_pkg::sadd(c.u6, c.u6);
                        n_ctx.u6x2  = s0.val;
                    end
                    S_A9: begin
                        s0          = tbv_pkg::sadd(c.u6x2, c.u6);
                        n_ctx.uxy   = s0.val;
                    end
                    S_A10: begin
                        s0          = tbv_pkg::sadd(c.m1, c.m2);
                        s1          = tbv_pkg::sadd(c.p3, c.p3);
                        s2          = tbv_pkg::sadd(c.m3, c.m4);
                        s3          = tbv_pkg::sadd(c.p2, c.p2);
                        n_ctx.e1    = s0.val;
                        n_ctx.e2    = s1.val;
                        n_ctx.e3    = s2.val;
                        n_ctx.e4    = s3.val;
                    end
                    S_A11: begin
                        s0          = tbv_pkg::sadd(c.e1, c.e2);
                        s1          = tbv_pkg::ssub(c.e3, c.e4);
                        n_ctx.d2    = s0.val;
                        n_ctx.d3    = s1.val;
                    end
                    default: ;
                endcase
                n_ctx.sat = c.sat | s0.sat | s1.sat | s2.sat | s3.sat;
            end
        end
    end

    // The last stage is the output register.
    assign o_valid               = r_vld[NSTG-1];
    assign o_word.dpos_x         = r_ctx[NSTG-1].vx;
    assign o_word.dpos_y         = r_ctx[NSTG-1].vy;
    assign o_word.dvel_x         = r_ctx[NSTG-1].ax;
    assign o_word.dvel_y         = r_ctx[NSTG-1].ay;
    assign o_word.dphi_row_zero  = r_ctx[NSTG-1].p2;
    assign o_word.dphi_row_one   = r_ctx[NSTG-1].p3;
    assign o_word.dphi_row_two   = r_ctx[NSTG-1].d2;
    assign o_word.dphi_row_three = r_ctx[NSTG-1].d3;
    assign o_word.overflow_flag  = r_ctx[NSTG-1].sat;

endmodule

`default_nettype wire

@@ rtl/core/tbv_chk.sv @@
// Port-level checker for the three-body variational right-hand side,
// bound to the top level. Depends on tbv_pkg for the output word type.
`default_nettype none

module tbv_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire tbv_pkg::t_out_word o_word
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    // A waiting result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_word))
        else $error("result word changed while stalled");

    // The input side stalls only when the output register is full and held.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled with room in the pipeline");

    // Reset empties the pipeline, seen here at the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

endmodule

bind three_body_variational_rhs tbv_chk u_tbv_chk (.*);

`default_nettype wire
